[rtl/utf8cf_pkg.sv]
`timescale 1ns / 1ps

package utf8cf_pkg;

    localparam int CP_W = 21;  // widest decoded code point (four-byte form)

    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_TAG  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_TAG  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_TAG  = 8'hF0;

    // Sequence length announced by a lead byte; 0 for a byte that cannot lead.
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        if (!b[7])
            return 3'd1;
        else if ((b & LEAD2_MASK) == LEAD2_TAG)
            return 3'd2;
        else if ((b & LEAD3_MASK) == LEAD3_TAG)
            return 3'd3;
        else if ((b & LEAD4_MASK) == LEAD4_TAG)
            return 3'd4;
        else
            return 3'd0;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_TAG;
    endfunction

    // Non-ASCII is always kept; ASCII only for letters and digits.
    function automatic logic is_kept(input logic [CP_W-1:0] v);
        if (v >= CP_W'('h80))
            return 1'b1;
        return (v >= CP_W'('h30) && v <= CP_W'('h39)) ||
               (v >= CP_W'('h41) && v <= CP_W'('h5A)) ||
               (v >= CP_W'('h61) && v <= CP_W'('h7A));
    endfunction

    function automatic logic [CP_W-1:0] to_lower(input logic [CP_W-1:0] v);
        if (v < CP_W'('h80))
            return (v >= CP_W'('h41) && v <= CP_W'('h5A)) ? v + CP_W'(32) : v;
        if (v == CP_W'('h0178))
            return CP_W'('h00FF);
        if (v >= CP_W'('h00C0) && v <= CP_W'('h00DE) && v != CP_W'('h00D7))
            return v + CP_W'(32);
        if (v >= CP_W'('h0100) && v <= CP_W'('h0137) && !v[0] && v != CP_W'('h0130))
            return v + CP_W'(1);
        if (v >= CP_W'('h0139) && v <= CP_W'('h0148) && v[0])
            return v + CP_W'(1);
        if (v >= CP_W'('h014A) && v <= CP_W'('h0177) && !v[0])
            return v + CP_W'(1);
        if (v >= CP_W'('h0179) && v <= CP_W'('h017E) && v[0])
            return v + CP_W'(1);
        if (v >= CP_W'('h0391) && v <= CP_W'('h03A9) && v != CP_W'('h03A2))
            return v + CP_W'(32);
        if (v >= CP_W'('h0410) && v <= CP_W'('h042F))
            return v + CP_W'(32);
        if (v >= CP_W'('h0400) && v <= CP_W'('h040F))
            return v + CP_W'(80);
        return v;
    endfunction

    function automatic logic [2:0] enc_len(input logic [CP_W-1:0] w);
        if (w < CP_W'('h80))
            return 3'd1;
        else if (w < CP_W'('h800))
            return 3'd2;
        else if (w < CP_W'('h10000))
            return 3'd3;
        else
            return 3'd4;
    endfunction

    // Byte idx of the UTF-8 encoding of w.
    function automatic logic [7:0] enc_byte(input logic [CP_W-1:0] w, input logic [1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (enc_len(w))
            3'd1: b = w[7:0];
            3'd2:
            begin
                case (idx)
                    2'd0:    b = LEAD2_TAG | {3'b000, w[10:6]};
                    default: b = CONT_TAG | {2'b00, w[5:0]};
                endcase
            end
            3'd3:
            begin
                case (idx)
                    2'd0:    b = LEAD3_TAG | {4'b0000, w[15:12]};
                    2'd1:    b = CONT_TAG | {2'b00, w[11:6]};
                    default: b = CONT_TAG | {2'b00, w[5:0]};
                endcase
            end
            default:
            begin
                case (idx)
                    2'd0:    b = LEAD4_TAG | {5'b00000, w[20:18]};
                    2'd1:    b = CONT_TAG | {2'b00, w[17:12]};
                    2'd2:    b = CONT_TAG | {2'b00, w[11:6]};
                    default: b = CONT_TAG | {2'b00, w[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

[rtl/utf8_case_fold_filter.sv]
`timescale 1ns / 1ps
// Each accepted byte passes the input register, then its results load the result buffer.
// Throughput: one input transfer per cycle while each byte yields at most one result
// and m_tready is high; a byte with more results holds the input while the port drains
// one transfer per cycle from an 8-entry result buffer, up to 8 per input byte.
// Reset (rst_n low, asynchronous): input stage, result buffer and held sequence cleared.
module utf8_case_fold_filter
    import utf8cf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_string
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [8] last_of_run, [15:9] zero
    output logic        m_tuser,   // has_byte
    output logic        m_tlast    // string_done
);

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Held bytes of an unfinished sequence, oldest first
    logic [7:0] pend_reg [3];
    logic [1:0] pcount_reg;

    // Result buffer, drained one transfer per cycle while m_tready is high
    logic       out_valid_reg;
    logic [7:0] obuf_reg [8];
    logic [2:0] ocnt_m1_reg;   // index of the final result
    logic [2:0] oidx_reg;
    logic       ohas_reg;
    logic       olast_reg;

    // ------------------------------------------------------------------
    // Scan of held bytes plus the new byte
    // ------------------------------------------------------------------
    logic [7:0]      buf4 [4];
    logic [2:0]      cnt;
    logic            p_stop  [4];
    logic [2:0]      p_adv   [4];
    logic            p_keep  [4];
    logic [2:0]      p_elen  [4];
    logic [7:0]      p_eb    [4][4];
    logic [7:0]      ob      [8];
    logic [3:0]      n;
    logic [2:0]      h_stop;
    logic            stopped;
    logic [7:0]      pend_next [3];
    logic [1:0]      pcount_next;

    assign cnt = {1'b0, pcount_reg} + 3'd1;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            buf4[k] = (3'(k) < {1'b0, pcount_reg} && k < 3) ? pend_reg[2'(k)] : in_byte_reg;
    end

    // Every start position is decoded on its own; the chain below picks the used ones.
    always_comb
    begin
        for (int p = 0; p < 4; p++)
        begin
            logic [7:0]      first;
            logic [2:0]      len;
            logic [2:0]      avail;
            logic            broken;
            logic [CP_W-1:0] cp;
            logic [CP_W-1:0] w;
            logic [7:0]      b1, b2, b3;

            first  = buf4[p];
            len    = lead_len(first);
            avail  = cnt - 3'(p);
            b1     = buf4[2'(p + 1)];
            b2     = buf4[2'(p + 2)];
            b3     = buf4[2'(p + 3)];
            broken = 1'b0;
            for (int k = 1; k < 4; k++)
            begin
                if (3'(k) < len && 3'(k) < avail && !is_cont(buf4[2'(p + k)]))
                    broken = 1'b1;
            end

            p_stop[p] = 1'b0;
            p_adv[p]  = 3'd1;
            cp        = CP_W'(first);
            if (len > 3'd1)
            begin
                if (!broken && avail < len)
                begin
                    if (!in_last_reg)
                        p_stop[p] = 1'b1;
                    else
                        broken = 1'b1;
                end
                if (!broken)
                begin
                    p_adv[p] = len;
                    case (len)
                        3'd2:    cp = CP_W'({first[4:0], b1[5:0]});
                        3'd3:    cp = CP_W'({first[3:0], b1[5:0], b2[5:0]});
                        default: cp = {first[2:0], b1[5:0], b2[5:0], b3[5:0]};
                    endcase
                end
            end

            w         = to_lower(cp);
            p_keep[p] = is_kept(cp);
            p_elen[p] = enc_len(w);
            for (int j = 0; j < 4; j++)
                p_eb[p][j] = enc_byte(w, 2'(j));
        end
    end

    // Walk the positions in order and pack emitted bytes.
    always_comb
    begin
        logic [2:0] h;
        logic       run;

        h       = 3'd0;
        run     = 1'b1;
        n       = 4'd0;
        for (int i = 0; i < 8; i++)
            ob[i] = 8'h00;
        for (int step = 0; step < 4; step++)
        begin
            if (run && h < cnt)
            begin
                if (p_stop[h[1:0]])
                    run = 1'b0;
                else
                begin
                    if (p_keep[h[1:0]])
                    begin
                        for (int j = 0; j < 4; j++)
                        begin
                            if (3'(j) < p_elen[h[1:0]] && n < 4'd8)
                            begin
                                ob[n[2:0]] = p_eb[h[1:0]][j];
                                n          = n + 4'd1;
                            end
                        end
                    end
                    h = h + p_adv[h[1:0]];
                end
            end
        end
        h_stop  = h;
        stopped = !run;
    end

    always_comb
    begin
        pcount_next = stopped ? 2'(cnt - h_stop) : 2'd0;
        for (int k = 0; k < 3; k++)
            pend_next[k] = buf4[h_stop[1:0] + 2'(k)];
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic out_final;
    logic out_done;
    logic has_result;
    logic consume;

    assign out_final  = (oidx_reg == ocnt_m1_reg);
    assign out_done   = out_valid_reg && m_tready && out_final;
    assign has_result = (n != 4'd0) || in_last_reg;
    assign consume    = in_valid_reg && (!has_result || !out_valid_reg || out_done);
    assign s_tready   = !in_valid_reg || consume;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = ohas_reg;
    assign m_tlast  = out_final && olast_reg;
    assign m_tdata  = {7'b0, out_final, (ohas_reg ? obuf_reg[oidx_reg] : 8'h00)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            pcount_reg    <= 2'd0;
            out_valid_reg <= 1'b0;
            oidx_reg      <= 3'd0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (consume)
                in_valid_reg <= 1'b0;

            if (consume)
                pcount_reg <= pcount_next;

            if (consume && has_result)
            begin
                out_valid_reg <= 1'b1;
                oidx_reg      <= 3'd0;
            end
            else if (out_done)
            begin
                out_valid_reg <= 1'b0;
                oidx_reg      <= 3'd0;
            end
            else if (out_valid_reg && m_tready)
                oidx_reg <= oidx_reg + 3'd1;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (consume)
        begin
            for (int k = 0; k < 3; k++)
                pend_reg[k] <= pend_next[k];
        end
        if (consume && has_result)
        begin
            for (int i = 0; i < 8; i++)
                obuf_reg[i] <= ob[i];
            ocnt_m1_reg <= (n == 4'd0) ? 3'd0 : 3'(n - 4'd1);
            ohas_reg    <= (n != 4'd0);
            olast_reg   <= in_last_reg;
        end
    end

endmodule
